/* rtl/canser_pkg.sv */
// shared types and constants for the can frame bit serializer
package canser_pkg;

  localparam int unsigned PayloadBytes = 8;
  localparam int unsigned StuffRun     = 5;

  localparam logic [14:0] CrcPoly  = 15'h4599;
  localparam int unsigned TailLast = 12;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    FK_SOF      = 4'd0,
    FK_ID       = 4'd1,
    FK_CONTROL  = 4'd2,
    FK_DLC      = 4'd3,
    FK_DATA     = 4'd4,
    FK_CRC      = 4'd5,
    FK_CRCDELIM = 4'd6,
    FK_ACK      = 4'd7,
    FK_ACKDELIM = 4'd8,
    FK_EOF      = 4'd9,
    FK_IFS      = 4'd10,
    FK_IDLE     = 4'd11
  } field_e;

  typedef struct packed {
    logic [28:0] id;
    logic        ext;
    logic        rtr;
    logic [3:0]  dlc;
  } hdr_t;

endpackage

/* rtl/can_frame_bit_serializer_top.sv */
// can 2.0b frame serializer with bit stuffing, top level
// a tick request's bit is registered and shows on the output in the cycle after acceptance
// throughput: one request per cycle while the result register is not stalled; a load request gives no result
// the bit is decoded from the state registers in a single pass
// reset: asynchronous, all state reset, block idle, line level recessive
// a load while a frame is in flight is dropped
module can_frame_bit_serializer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [28:0] frame_id_i,
  input  logic        extended_i,
  input  logic        remote_i,
  input  logic [3:0]  length_code_i,
  input  logic [63:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        level_o,
  output logic [3:0]  field_kind_o,
  output logic        stuffed_o,
  output logic        frame_end_o,
  output logic        active_o
);

  // frame state
  canser_pkg::hdr_t hdr_q, hdr_d;
  logic [63:0] frame_q, frame_d;
  logic [7:0]  pos_q, pos_d;
  logic [14:0] crc_q, crc_d;
  logic [2:0]  run_q, run_d;
  logic        last_q, last_d;
  logic        pend_q, pend_d;
  logic        busy_q, busy_d;

  // result register
  logic               ovalid_q, ovalid_d;
  logic               level_q, level_d;
  canser_pkg::field_e kind_q, kind_d;
  logic               stuffed_q, stuffed_d;
  logic               fend_q, fend_d;
  logic               active_q, active_d;

  // span decoder
  logic               span_level;
  canser_pkg::field_e span_kind;
  logic [7:0]         span_len;
  logic [7:0]         sel_pos;
  logic [7:0]         tail_pos;
  logic               fb;
  logic               accept;

  // result register drains or is empty: take the next request
  assign in_ready_o = !ovalid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // a stuff bit reuses the field tag of the bit before it
  assign sel_pos  = (pend_q && pos_q != 8'd0) ? pos_q - 8'd1 : pos_q;
  assign tail_pos = pos_q - span_len;
  assign fb       = span_level ^ crc_q[14];

  canser_span u_span (
    .hdr_i      (hdr_q),
    .frame_i    (frame_q),
    .crc_i      (crc_q),
    .pos_i      (sel_pos),
    .level_o    (span_level),
    .kind_o     (span_kind),
    .span_len_o (span_len)
  );

  always_comb begin
    hdr_d     = hdr_q;
    frame_d   = frame_q;
    pos_d     = pos_q;
    crc_d     = crc_q;
    run_d     = run_q;
    last_d    = last_q;
    pend_d    = pend_q;
    busy_d    = busy_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    level_d   = level_q;
    kind_d    = kind_q;
    stuffed_d = stuffed_q;
    fend_d    = fend_q;
    active_d  = active_q;

    if (accept) begin
      if (command_i == canser_pkg::CMD_LOAD) begin
        // latch a new frame when idle
        if (!busy_q) begin
          hdr_d   = '{id: frame_id_i, ext: extended_i, rtr: remote_i, dlc: length_code_i};
          frame_d = payload_i;
          pos_d   = 8'd0;
          crc_d   = '0;
          run_d   = 3'd0;
          last_d  = 1'b1;
          pend_d  = 1'b0;
          busy_d  = 1'b1;
        end
      end else begin
        ovalid_d  = 1'b1;
        level_d   = 1'b1;
        kind_d    = canser_pkg::FK_IDLE;
        stuffed_d = 1'b0;
        fend_d    = 1'b0;
        active_d  = busy_q;
        if (busy_q) begin
          if (pend_q) begin
            // complementary stuff bit, opens a new run
            level_d   = ~last_q;
            kind_d    = span_kind;
            last_d    = ~last_q;
            run_d     = 3'd1;
            pend_d    = 1'b0;
            stuffed_d = 1'b1;
          end else if (pos_q < span_len) begin
            level_d = span_level;
            kind_d  = span_kind;
            // crc-15 runs over sof through data
            if (span_kind != canser_pkg::FK_CRC) begin
              crc_d = {crc_q[13:0], 1'b0} ^ (fb ? canser_pkg::CrcPoly : 15'd0);
            end
            if (span_level == last_q) begin
              run_d = run_q + 3'd1;
            end else begin
              last_d = span_level;
              run_d  = 3'd1;
            end
            if (run_d >= 3'(canser_pkg::StuffRun)) begin
              pend_d = 1'b1;
            end
            pos_d = pos_q + 8'd1;
          end else begin
            // unstuffed tail: delimiters, ack, eof, intermission
            if (tail_pos == 8'd0) begin
              kind_d = canser_pkg::FK_CRCDELIM;
            end else if (tail_pos == 8'd1) begin
              kind_d = canser_pkg::FK_ACK;
            end else if (tail_pos == 8'd2) begin
              kind_d = canser_pkg::FK_ACKDELIM;
            end else if (tail_pos < 8'd10) begin
              kind_d = canser_pkg::FK_EOF;
            end else begin
              kind_d = canser_pkg::FK_IFS;
            end
            if (tail_pos >= 8'(canser_pkg::TailLast)) begin
              fend_d = 1'b1;
              busy_d = 1'b0;
              pos_d  = 8'd0;
            end else begin
              pos_d = pos_q + 8'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q     <= '0;
      frame_q   <= '0;
      pos_q     <= '0;
      crc_q     <= '0;
      run_q     <= '0;
      last_q    <= 1'b1;
      pend_q    <= 1'b0;
      busy_q    <= 1'b0;
      ovalid_q  <= 1'b0;
      level_q   <= 1'b1;
      kind_q    <= canser_pkg::FK_IDLE;
      stuffed_q <= 1'b0;
      fend_q    <= 1'b0;
      active_q  <= 1'b0;
    end else begin
      hdr_q     <= hdr_d;
      frame_q   <= frame_d;
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      run_q     <= run_d;
      last_q    <= last_d;
      pend_q    <= pend_d;
      busy_q    <= busy_d;
      ovalid_q  <= ovalid_d;
      level_q   <= level_d;
      kind_q    <= kind_d;
      stuffed_q <= stuffed_d;
      fend_q    <= fend_d;
      active_q  <= active_d;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign level_o      = level_q;
  assign field_kind_o = kind_q;
  assign stuffed_o    = stuffed_q;
  assign frame_end_o  = fend_q;
  assign active_o     = active_q;

endmodule

/* rtl/canser_span.sv */
// decoder for one unstuffed bit of the sof-through-crc span
module canser_span (
  input  canser_pkg::hdr_t   hdr_i,
  input  logic [63:0]        frame_i,
  input  logic [14:0]        crc_i,
  input  logic [7:0]         pos_i,
  output logic               level_o,
  output canser_pkg::field_e kind_o,
  output logic [7:0]         span_len_o
);

  logic [3:0]  byte_cnt;
  logic [7:0]  dlc_start;
  logic [7:0]  crc_start;
  logic [10:0] base_id;
  logic [7:0]  id_idx;
  logic [7:0]  ext_idx;
  logic [7:0]  dlc_idx;
  logic [7:0]  data_idx;
  logic [7:0]  crc_idx;

  always_comb begin
    if (hdr_i.rtr) begin
      byte_cnt = 4'd0;
    end else if (hdr_i.dlc < 4'(canser_pkg::PayloadBytes)) begin
      byte_cnt = hdr_i.dlc;
    end else begin
      byte_cnt = 4'(canser_pkg::PayloadBytes);
    end
  end

  assign dlc_start  = hdr_i.ext ? 8'd35 : 8'd15;
  assign crc_start  = dlc_start + 8'd4 + {1'b0, byte_cnt, 3'b000};
  assign span_len_o = crc_start + 8'd15;
  assign base_id    = hdr_i.ext ? hdr_i.id[28:18] : hdr_i.id[10:0];

  assign id_idx   = 8'd11 - pos_i;
  assign ext_idx  = 8'd31 - pos_i;
  assign dlc_idx  = dlc_start + 8'd3 - pos_i;
  assign data_idx = pos_i - dlc_start - 8'd4;
  assign crc_idx  = 8'd14 - (pos_i - crc_start);

  always_comb begin
    level_o = 1'b1;
    kind_o  = canser_pkg::FK_CRC;
    if (pos_i == 8'd0) begin
      level_o = 1'b0;
      kind_o  = canser_pkg::FK_SOF;
    end else if (pos_i <= 8'd11) begin
      level_o = base_id[id_idx[3:0]];
      kind_o  = canser_pkg::FK_ID;
    end else if (pos_i < dlc_start) begin
      // srr/ide, extended id bits, rtr and reserved bits
      if (!hdr_i.ext) begin
        kind_o  = canser_pkg::FK_CONTROL;
        level_o = (pos_i == 8'd12) ? hdr_i.rtr : 1'b0;
      end else if (pos_i == 8'd12 || pos_i == 8'd13) begin
        kind_o  = canser_pkg::FK_CONTROL;
        level_o = 1'b1;
      end else if (pos_i <= 8'd31) begin
        kind_o  = canser_pkg::FK_ID;
        level_o = hdr_i.id[ext_idx[4:0]];
      end else begin
        kind_o  = canser_pkg::FK_CONTROL;
        level_o = (pos_i == 8'd32) ? hdr_i.rtr : 1'b0;
      end
    end else if (pos_i < dlc_start + 8'd4) begin
      kind_o  = canser_pkg::FK_DLC;
      level_o = hdr_i.dlc[dlc_idx[1:0]];
    end else if (pos_i < crc_start) begin
      kind_o  = canser_pkg::FK_DATA;
      level_o = frame_i[~data_idx[5:0]];
    end else begin
      kind_o  = canser_pkg::FK_CRC;
      level_o = crc_i[crc_idx[3:0]];
    end
  end

endmodule

/* rtl/canser_checker.sv */
// port-level checks for the can frame bit serializer
module canser_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       level_o,
  input logic [3:0] field_kind_o,
  input logic       stuffed_o,
  input logic       frame_end_o,
  input logic       active_o
);

  // a stalled result holds its bit
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(level_o)
      && $stable(field_kind_o) && $stable(stuffed_o))
    else $error("stalled result changed");

  // input backpressure only from a stalled result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request refused without a stalled result");

  // idle bits are recessive idle tags
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !active_o |-> level_o && !stuffed_o && !frame_end_o
      && field_kind_o == canser_pkg::FK_IDLE)
    else $error("bad idle bit");

  // frame end lands on a recessive intermission bit
  a_fend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> active_o && level_o && !stuffed_o
      && field_kind_o == canser_pkg::FK_IFS)
    else $error("bad frame end bit");

  // stuff bits only inside the stuffed span
  a_stuff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stuffed_o |-> active_o && field_kind_o <= canser_pkg::FK_CRC)
    else $error("stuff bit outside span");

endmodule

bind can_frame_bit_serializer_top canser_checker u_canser_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .level_o      (level_o),
  .field_kind_o (field_kind_o),
  .stuffed_o    (stuffed_o),
  .frame_end_o  (frame_end_o),
  .active_o     (active_o)
);

/* dv/can_frame_bit_serializer_checker.sv */
// request/result monitor with a bit-level model of the can frame serializer
module can_frame_bit_serializer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        command_i,
  input  logic [28:0] frame_id_i,
  input  logic        extended_i,
  input  logic        remote_i,
  input  logic [3:0]  length_code_i,
  input  logic [63:0] payload_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        level_i,
  input  logic [3:0]  field_kind_i,
  input  logic        stuffed_i,
  input  logic        frame_end_i,
  input  logic        active_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic               level;
    canser_pkg::field_e kind;
    logic               stuffed;
    logic               frame_end;
    logic               active;
  } wire_bit_t;

  // frame being sent
  logic [63:0]      tx_data;
  canser_pkg::hdr_t tx_hdr;
  int unsigned      tx_pos;
  logic [14:0]      tx_crc;
  logic [2:0]       tx_run;
  logic             tx_last;
  logic             tx_stuff_due;
  logic             tx_busy;

  wire_bit_t   wire_bits_q[$];
  wire_bit_t   next_bit;
  wire_bit_t   seen_bit;
  int unsigned result_no;
  int          mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic int unsigned data_bytes();
    if (tx_hdr.rtr) return 0;
    return (tx_hdr.dlc < canser_pkg::PayloadBytes) ? tx_hdr.dlc : canser_pkg::PayloadBytes;
  endfunction

  function automatic int unsigned dlc_start();
    return tx_hdr.ext ? 35 : 15;
  endfunction

  function automatic int unsigned crc_start();
    return dlc_start() + 4 + 8 * data_bytes();
  endfunction

  // level and field of unstuffed bit p, sof through crc
  function automatic void bit_at(input int unsigned p, output logic lvl,
                                 output canser_pkg::field_e kind);
    int unsigned ds;
    int unsigned cs;
    int unsigned k;
    logic [10:0] base;
    ds   = dlc_start();
    cs   = crc_start();
    base = tx_hdr.ext ? tx_hdr.id[28:18] : tx_hdr.id[10:0];
    lvl  = 1'b1;
    kind = canser_pkg::FK_CRC;
    if (p == 0) begin
      lvl  = 1'b0;
      kind = canser_pkg::FK_SOF;
    end else if (p <= 11) begin
      lvl  = base[11-p];
      kind = canser_pkg::FK_ID;
    end else if (p < ds) begin
      if (!tx_hdr.ext) begin
        kind = canser_pkg::FK_CONTROL;
        lvl  = (p == 12) ? tx_hdr.rtr : 1'b0;
      end else if (p <= 13) begin
        kind = canser_pkg::FK_CONTROL;
        lvl  = 1'b1;
      end else if (p <= 31) begin
        kind = canser_pkg::FK_ID;
        lvl  = tx_hdr.id[31-p];
      end else begin
        kind = canser_pkg::FK_CONTROL;
        lvl  = (p == 32) ? tx_hdr.rtr : 1'b0;
      end
    end else if (p < ds + 4) begin
      kind = canser_pkg::FK_DLC;
      lvl  = tx_hdr.dlc[ds+3-p];
    end else if (p < cs) begin
      kind = canser_pkg::FK_DATA;
      lvl  = tx_data[63-(p-ds-4)];
    end else begin
      k    = p - cs;
      if (k > 14) k = 14;
      kind = canser_pkg::FK_CRC;
      lvl  = tx_crc[14-k];
    end
  endfunction

  // wire bit for one tick, advancing the frame state
  task automatic clock_out_bit(output wire_bit_t b);
    int unsigned        span;
    int unsigned        t;
    logic               lvl;
    canser_pkg::field_e kind;
    b = '{level: 1'b1, kind: canser_pkg::FK_IDLE, stuffed: 1'b0, frame_end: 1'b0,
          active: 1'b0};
    if (tx_busy) begin
      span     = crc_start() + 15;
      b.active = 1'b1;
      if (tx_stuff_due) begin
        // stuff bit takes the field of the bit it follows
        bit_at((tx_pos != 0) ? tx_pos - 1 : 0, lvl, kind);
        b.level      = ~tx_last;
        b.kind       = kind;
        b.stuffed    = 1'b1;
        tx_last      = b.level;
        tx_run       = 3'd1;
        tx_stuff_due = 1'b0;
      end else if (tx_pos < span) begin
        bit_at(tx_pos, lvl, kind);
        b.level = lvl;
        b.kind  = kind;
        if (kind != canser_pkg::FK_CRC) begin
          tx_crc = {tx_crc[13:0], 1'b0} ^ ((lvl ^ tx_crc[14]) ? canser_pkg::CrcPoly : 15'h0);
        end
        if (lvl == tx_last) begin
          tx_run = tx_run + 3'd1;
        end else begin
          tx_last = lvl;
          tx_run  = 3'd1;
        end
        if (tx_run >= canser_pkg::StuffRun) tx_stuff_due = 1'b1;
        tx_pos++;
      end else begin
        t = tx_pos - span;
        if (t == 0)       b.kind = canser_pkg::FK_CRCDELIM;
        else if (t == 1)  b.kind = canser_pkg::FK_ACK;
        else if (t == 2)  b.kind = canser_pkg::FK_ACKDELIM;
        else if (t < 10)  b.kind = canser_pkg::FK_EOF;
        else              b.kind = canser_pkg::FK_IFS;
        if (t >= canser_pkg::TailLast) begin
          b.frame_end = 1'b1;
          tx_busy     = 1'b0;
          tx_pos      = 0;
        end else begin
          tx_pos++;
        end
      end
    end
  endtask

  task automatic report_error(input string msg);
    $display("error at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_bit(input wire_bit_t got, input wire_bit_t want);
    if (got.level !== want.level)
      report_error($sformatf("bit %0d level %b, want %b", result_no, got.level, want.level));
    if (got.kind !== want.kind)
      report_error($sformatf("bit %0d field %0d, want %s", result_no, got.kind, want.kind.name()));
    if (got.stuffed !== want.stuffed)
      report_error($sformatf("bit %0d stuffed %b, want %b", result_no, got.stuffed, want.stuffed));
    if (got.frame_end !== want.frame_end)
      report_error($sformatf("bit %0d frame_end %b, want %b", result_no, got.frame_end,
                             want.frame_end));
    if (got.active !== want.active)
      report_error($sformatf("bit %0d active %b, want %b", result_no, got.active, want.active));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_data      = '0;
      tx_hdr       = '0;
      tx_pos       = 0;
      tx_crc       = '0;
      tx_run       = '0;
      tx_last      = 1'b1;
      tx_stuff_due = 1'b0;
      tx_busy      = 1'b0;
      result_no    = 0;
      mismatches   = 0;
      wire_bits_q.delete();
      pending_o   <= 0;
    end else begin
      // results first, each answers a tick taken at an earlier edge
      if (out_valid_i && out_ready_i) begin
        seen_bit = {level_i, field_kind_i, stuffed_i, frame_end_i, active_i};
        if (wire_bits_q.size() == 0)
          report_error($sformatf("bit %0d came with no tick waiting", result_no));
        else
          compare_bit(seen_bit, wire_bits_q.pop_front());
        result_no++;
      end
      if (in_valid_i && in_ready_i) begin
        if (command_i == canser_pkg::CMD_TICK) begin
          clock_out_bit(next_bit);
          wire_bits_q = {wire_bits_q, next_bit};
        end else if (!tx_busy) begin
          tx_data      = payload_i;
          tx_hdr.id    = frame_id_i;
          tx_hdr.ext   = extended_i;
          tx_hdr.rtr   = remote_i;
          tx_hdr.dlc   = length_code_i;
          tx_pos       = 0;
          tx_crc       = '0;
          tx_run       = '0;
          tx_last      = 1'b1;
          tx_stuff_due = 1'b0;
          tx_busy      = 1'b1;
        end
      end
      pending_o <= wire_bits_q.size();
    end
  end

endmodule

/* dv/tb_can_frame_bit_serializer_top.sv */
// testbench top for the can frame bit serializer: stimulus, idling and verdict
module tb_can_frame_bit_serializer_top;

  // ticks and loads over the whole run
  localparam int unsigned ItemTarget = 700;
  // cycles without any accepted request or result before giving up
  localparam int unsigned StallLimit = 1000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic        command       = canser_pkg::CMD_TICK;
  logic [28:0] frame_id      = '0;
  logic        extended      = 1'b0;
  logic        remote        = 1'b0;
  logic [3:0]  length_code   = '0;
  logic [63:0] payload       = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic        level;
  logic [3:0]  field_kind;
  logic        stuffed;
  logic        frame_end;
  logic        active;

  int          fail_count;
  int          expected_left;
  int unsigned burst_left    = 0;
  int unsigned items_sent    = 0;
  int unsigned idle_cycles;
  logic [8:0]  stall_phase   = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  can_frame_bit_serializer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .command_i     (command),
    .frame_id_i    (frame_id),
    .extended_i    (extended),
    .remote_i      (remote),
    .length_code_i (length_code),
    .payload_i     (payload),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .level_o       (level),
    .field_kind_o  (field_kind),
    .stuffed_o     (stuffed),
    .frame_end_o   (frame_end),
    .active_o      (active)
  );

  can_frame_bit_serializer_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .command_i     (command),
    .frame_id_i    (frame_id),
    .extended_i    (extended),
    .remote_i      (remote),
    .length_code_i (length_code),
    .payload_i     (payload),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .level_i       (level),
    .field_kind_i  (field_kind),
    .stuffed_i     (stuffed),
    .frame_end_i   (frame_end),
    .active_i      (active),
    .fail_count_o  (fail_count),
    .pending_o     (expected_left)
  );

  // receiver stalls: the mode is taken from the top two bits of a free-running phase counter
  // always ready, mostly ready, low whenever the two low phase bits are zero, coin flip
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 9'd1;
    case (stall_phase[8:7])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= (stall_phase[1:0] != 2'd0);
      default: out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // ticks enough to finish a frame, allowing for the worst stuffing
  function automatic int unsigned tick_budget(input logic ext, input logic rtr,
                                              input logic [3:0] dlc);
    int unsigned nbytes;
    int unsigned span;
    nbytes = rtr ? 0 : ((dlc < canser_pkg::PayloadBytes) ? dlc : canser_pkg::PayloadBytes);
    span   = (ext ? 35 : 15) + 4 + 8 * nbytes + 15;
    return span + span / 4 + canser_pkg::TailLast + 1;
  endfunction

  // one request, sent in bursts with random gaps between them;
  // drives at the falling edge and returns at the edge that takes it
  task automatic push_request(input canser_pkg::cmd_e cmd, input logic [28:0] id,
                              input logic ext, input logic rtr, input logic [3:0] dlc,
                              input logic [63:0] pay);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        // long stretch with no idling
        burst_left = $urandom_range(40, 120);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(0, 6);
      end
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    command     <= cmd;
    frame_id    <= id;
    extended    <= ext;
    remote      <= rtr;
    length_code <= dlc;
    payload     <= pay;
    items_sent++;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // a tick carries random don't-care fields
  task automatic send_tick();
    push_request(canser_pkg::CMD_TICK, 29'($urandom), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), {$urandom, $urandom});
  endtask

  // load a frame, then clock it out; a stray load lands mid-frame and is dropped
  task automatic run_frame(input logic [28:0] id, input logic ext, input logic rtr,
                           input logic [3:0] dlc, input logic [63:0] pay,
                           input int unsigned ticks, input bit stray_load);
    int unsigned n;
    push_request(canser_pkg::CMD_LOAD, id, ext, rtr, dlc, pay);
    for (n = 0; n < ticks; n++) begin
      if (stray_load && n == ticks / 3) begin
        push_request(canser_pkg::CMD_LOAD, 29'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                     {$urandom, $urandom});
      end
      send_tick();
    end
  endtask

  // hold the sender until every predicted bit has come out
  task automatic drain_results();
    @(negedge clk_i);
    in_valid  <= 1'b0;
    burst_left = 0;
    while (expected_left != 0) @(posedge clk_i);
  endtask

  // watchdog: ends the run when nothing moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic        ext;
    logic        rtr;
    logic [3:0]  dlc;
    logic [28:0] id;
    logic [63:0] pay;
    int unsigned ticks;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // ticks with no frame loaded give idle recessive bits
    send_tick();
    send_tick();
    drain_results();

    // shortest frame: standard remote with zero id and length code, stuffing everywhere
    run_frame('0, 1'b0, 1'b1, 4'd0, '0, tick_budget(1'b0, 1'b1, 4'd0) + 4, 1'b0);
    drain_results();

    // longest frame: extended, recessive id and data, length code above eight,
    // plus a load while busy that must be dropped
    run_frame('1, 1'b1, 1'b0, 4'd15, '1, tick_budget(1'b1, 1'b0, 4'd15) + 4, 1'b1);
    drain_results();

    // standard frame: unused high id bits set, eight bytes of mixed runs
    run_frame(29'h1FFFF800 | 29'h7FF, 1'b0, 1'b0, 4'd8, 64'h00FF_AAAA_5555_FF00,
              tick_budget(1'b0, 1'b0, 4'd8) + 4, 1'b0);
    drain_results();

    // extended remote with a nonzero length code sends no data
    run_frame('0, 1'b1, 1'b1, 4'd8, '1, tick_budget(1'b1, 1'b1, 4'd8) + 4, 1'b0);
    drain_results();

    // standard frame, length code nine, random bytes
    run_frame(29'($urandom), 1'b0, 1'b0, 4'd9, {$urandom, $urandom},
              tick_budget(1'b0, 1'b0, 4'd9) + 4, 1'b0);

    // random frames, mostly short so that many complete
    while (items_sent < ItemTarget) begin
      ext = 1'($urandom_range(0, 1));
      rtr = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: dlc = 4'($urandom_range(0, 2));
        7, 8:                dlc = 4'($urandom_range(3, 8));
        default:             dlc = 4'($urandom_range(9, 15));
      endcase
      case ($urandom_range(0, 3))
        0:       id = '0;
        1:       id = '1;
        default: id = 29'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       pay = '0;
        1:       pay = '1;
        2:       pay = {8{8'($urandom)}};
        default: pay = {$urandom, $urandom};
      endcase
      ticks = tick_budget(ext, rtr, dlc);
      // sometimes cut short so the next load arrives while still busy
      if ($urandom_range(0, 5) == 0) ticks = ticks - $urandom_range(5, 30);
      else ticks = ticks + $urandom_range(0, 6);
      run_frame(id, ext, rtr, dlc, pay, ticks, $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
